// ===== rtl/core/false_color_colormap_top_macros.svh =====
// Assertion helpers for the false colour map.
`ifndef FALSE_COLOR_COLORMAP_TOP_MACROS_SVH
`define FALSE_COLOR_COLORMAP_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define FCC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcc assertion failed");

`define FCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcc assertion failed");

`else

`define FCC_ASSERT_IMPL(label, ante, cons)

`define FCC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/fcc_pkg.sv =====
package fcc_pkg;

  localparam int N_STOPS = 12;
  localparam int IDX_W   = 4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [7:0]       chan_t;
  typedef logic [1:0]       mode_t;

  localparam mode_t MODE_ZERO = 2'd0;
  localparam mode_t MODE_ONE  = 2'd1;
  localparam mode_t MODE_DIV  = 2'd2;

  localparam idx_t               LAST_IDX   = 4'd11;
  localparam logic [16:0]        FRAC_ONE   = 17'h10000;
  localparam logic [25:0]        ROUND_HALF = 26'd32768;
  localparam logic signed [31:0] FS_RESET   = 32'sd65536;

  localparam chan_t STOP_TAB [N_STOPS][3] = '{
    '{8'd4,   8'd2,   8'd18},
    '{8'd38,  8'd4,   8'd54},
    '{8'd68,  8'd10,  8'd84},
    '{8'd88,  8'd20,  8'd110},
    '{8'd110, 8'd40,  8'd120},
    '{8'd130, 8'd60,  8'd110},
    '{8'd160, 8'd70,  8'd80},
    '{8'd195, 8'd80,  8'd50},
    '{8'd230, 8'd120, 8'd40},
    '{8'd252, 8'd180, 8'd40},
    '{8'd252, 8'd230, 8'd120},
    '{8'd255, 8'd255, 8'd220}
  };

endpackage

// ===== rtl/core/fcc_in_if.sv =====
interface fcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/core/fcc_out_if.sv =====
interface fcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/false_color_colormap_top.sv =====
// Channel   Dir   Payload               Request taken when
// in_req    in    sample (s32 Q16.16)   valid && ready
// out_req   out   red, green, blue (u8) valid && ready
// cfg_wr    in    full_scale (s32)      cfg_wr_en high
//
// One request per cycle while the skid register is empty.
// A sample passes through the 16-stage restoring divider, one quotient bit a stage,
// followed by scale, stop lookup, multiply and round stages.
// Synchronous reset clears all valid bits and loads full_scale with 1.0.
// A stalled output parks one colour in a skid register; in_req.ready drops only
// while that register is full, and the whole pipeline then holds.
`include "false_color_colormap_top_macros.svh"

module false_color_colormap_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  fcc_in_if.sink      in_req,
  fcc_out_if.source   out_req
);

  import fcc_pkg::*;

  localparam int DIV_STEPS = 16;

  logic signed [31:0] fs_r;
  logic [31:0]        fs_mag;
  logic               adv;

  logic [DIV_STEPS:0] dv_vld_r;
  mode_t              dv_mode_r [DIV_STEPS+1];
  logic [31:0]        dv_rem_r  [DIV_STEPS+1];
  logic [15:0]        dv_quo_r  [DIV_STEPS+1];
  mode_t              dv_mode_nxt;
  logic [31:0]        dv_rem_nxt [DIV_STEPS+1];
  logic [15:0]        dv_quo_nxt [DIV_STEPS+1];

  logic [16:0] frac;
  logic [19:0] scl_full;
  logic        a_vld_r;
  mode_t       a_mode_r;
  logic [19:0] a_scl_r;

  idx_t               lo_idx;
  idx_t               hi_idx;
  logic               b_vld_r;
  chan_t              b_x_r [3];
  logic signed [8:0]  b_d_r [3];
  logic [15:0]        b_w_r;
  chan_t              b_x_nxt [3];
  logic signed [8:0]  b_d_nxt [3];

  logic               c_vld_r;
  chan_t              c_x_r [3];
  logic signed [25:0] c_prod_r [3];
  logic signed [25:0] c_prod_nxt [3];

  chan_t              d_rgb [3];
  logic               out_vld_r;
  logic               skid_vld_r;
  chan_t              out_rgb_r [3];
  chan_t              skid_rgb_r [3];

  assign fs_mag       = {1'b0, fs_r[30:0]};
  assign adv          = !skid_vld_r;
  assign in_req.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_RESET;
    end else if (cfg_wr_en) begin
      fs_r <= cfg_wr_data;
    end
  end

  always_comb begin
    logic [31:0] sh;
    sh = '0;
    if (fs_r <= 32'sd0 || in_req.sample <= 32'sd0) begin
      dv_mode_nxt = MODE_ZERO;
    end else if (in_req.sample >= fs_r) begin
      dv_mode_nxt = MODE_ONE;
    end else begin
      dv_mode_nxt = MODE_DIV;
    end
    dv_rem_nxt[0] = in_req.sample;
    dv_quo_nxt[0] = '0;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      sh = {dv_rem_r[k-1][30:0], 1'b0};
      if (sh >= fs_mag) begin
        dv_rem_nxt[k] = sh - fs_mag;
        dv_quo_nxt[k] = {dv_quo_r[k-1][14:0], 1'b1};
      end else begin
        dv_rem_nxt[k] = sh;
        dv_quo_nxt[k] = {dv_quo_r[k-1][14:0], 1'b0};
      end
    end
  end

  always_comb begin
    case (dv_mode_r[DIV_STEPS])
      MODE_ONE: frac = FRAC_ONE;
      MODE_DIV: frac = {1'b0, dv_quo_r[DIV_STEPS]};
      default:  frac = '0;
    endcase
    scl_full = 20'(frac) * 20'd11;
  end

  always_comb begin
    if (a_scl_r[19:16] >= LAST_IDX) begin
      lo_idx = LAST_IDX;
      hi_idx = LAST_IDX;
    end else begin
      lo_idx = a_scl_r[19:16];
      hi_idx = a_scl_r[19:16] + 4'd1;
    end
    for (int c = 0; c < 3; c++) begin
      b_x_nxt[c] = STOP_TAB[lo_idx][c];
      b_d_nxt[c] = $signed({1'b0, STOP_TAB[hi_idx][c]}) - $signed({1'b0, STOP_TAB[lo_idx][c]});
    end
  end

  always_comb begin
    logic signed [25:0] acc;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      c_prod_nxt[c] = 26'(b_d_r[c]) * 26'($signed({1'b0, b_w_r}));
      acc = $signed({2'b00, c_x_r[c], 16'h0000}) + c_prod_r[c] + $signed(ROUND_HALF);
      d_rgb[c] = acc[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
    end else if (adv) begin
      dv_vld_r <= {dv_vld_r[DIV_STEPS-1:0], in_req.valid};
      a_vld_r  <= dv_vld_r[DIV_STEPS];
      b_vld_r  <= a_vld_r;
      c_vld_r  <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_mode_r[0] <= dv_mode_nxt;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_quo_r[k] <= dv_quo_nxt[k];
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
        dv_mode_r[k] <= dv_mode_r[k-1];
      end
      a_mode_r <= dv_mode_r[DIV_STEPS];
      a_scl_r  <= scl_full;
      b_w_r    <= a_scl_r[15:0];
      for (int c = 0; c < 3; c++) begin
        b_x_r[c]    <= b_x_nxt[c];
        b_d_r[c]    <= b_d_nxt[c];
        c_x_r[c]    <= b_x_r[c];
        c_prod_r[c] <= c_prod_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_req.ready) begin
      if (adv && c_vld_r) begin
        skid_vld_r <= 1'b1;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !out_req.ready) begin
      if (!skid_vld_r) begin
        skid_rgb_r <= d_rgb;
      end
    end else if (skid_vld_r) begin
      out_rgb_r <= skid_rgb_r;
    end else begin
      out_rgb_r <= d_rgb;
    end
  end

  assign out_req.valid = out_vld_r;
  assign out_req.red   = out_rgb_r[0];
  assign out_req.green = out_rgb_r[1];
  assign out_req.blue  = out_rgb_r[2];

  `FCC_ASSERT_IMPL(a_rem_below_fs, dv_vld_r[DIV_STEPS] && (dv_mode_r[DIV_STEPS] == MODE_DIV), dv_rem_r[DIV_STEPS] < fs_mag)
  `FCC_ASSERT_IMPL(a_idx_range, a_vld_r, a_scl_r[19:16] <= LAST_IDX)
  `FCC_ASSERT_IMPL(a_zero_frac, a_vld_r && (a_mode_r == MODE_ZERO), a_scl_r == '0)
  `FCC_ASSERT_IMPL(a_skid_behind_out, skid_vld_r, out_vld_r)
  `FCC_ASSERT_NEXT(a_skid_drain, skid_vld_r && out_req.ready, out_vld_r && !skid_vld_r)

endmodule
